### src/wsfcs_pkg.sv
// shared types and constants for the led strip frame code serializer
package wsfcs_pkg;

    localparam int LED_COUNT   = 64;
    localparam int LED_AW      = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int COLOR_BITS  = 24;
    localparam int BIT_W       = $clog2(COLOR_BITS);
    localparam int OP_W        = 3;
    localparam int IDX_W       = 10;
    localparam int CODE_W      = 8;
    localparam int CFG_INDEX_W = 1;
    localparam int S_DATA_W    = 40;
    localparam int M_DATA_W    = 8;

    localparam logic [BIT_W-1:0]  BIT_MSB  = BIT_W'(COLOR_BITS - 1);
    localparam logic [LED_AW-1:0] LED_LAST = LED_AW'(LED_COUNT - 1);

    localparam logic [CODE_W-1:0] ONE_CODE_RST  = 8'd248;
    localparam logic [CODE_W-1:0] ZERO_CODE_RST = 8'd192;

    typedef enum logic [OP_W-1:0] {
        OP_SET_PIXEL = 3'd0,
        OP_CLR_PIXEL = 3'd1,
        OP_CLR_ALL   = 3'd2,
        OP_FILL_ALL  = 3'd3,
        OP_START     = 3'd4,
        OP_TICK      = 3'd5
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ONE_CODE  = 1'b0,
        REG_ZERO_CODE = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EMIT = 1'b1
    } state_t;

    typedef struct packed {
        logic set_pixel;
        logic clr_pixel;
        logic clr_all;
        logic fill_all;
        logic start;
        logic rd_issue;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic sending;
        logic out_free;
    } ctrl_status_t;

endpackage

### src/wsfcs_ctrl.sv
// controller: op decode and the tick read / emit sequence
module wsfcs_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [wsfcs_pkg::OP_W-1:0]     op,
    input  wsfcs_pkg::ctrl_status_t        status,
    output wsfcs_pkg::ctrl_cmd_t           cmd
);

    wsfcs_pkg::state_t state_reg;
    wsfcs_pkg::state_t state_next;
    logic              accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wsfcs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign accept = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wsfcs_pkg::ST_IDLE:
            begin
                if (cmd.rd_issue)
                begin
                    state_next = wsfcs_pkg::ST_EMIT;
                end
            end
            wsfcs_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = wsfcs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wsfcs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = (state_reg == wsfcs_pkg::ST_IDLE);
        cmd      = '0;
        if (accept)
        begin
            unique case (wsfcs_pkg::op_t'(op))
                wsfcs_pkg::OP_SET_PIXEL: cmd.set_pixel = 1'b1;
                wsfcs_pkg::OP_CLR_PIXEL: cmd.clr_pixel = 1'b1;
                wsfcs_pkg::OP_CLR_ALL:   cmd.clr_all   = 1'b1;
                wsfcs_pkg::OP_FILL_ALL:  cmd.fill_all  = 1'b1;
                wsfcs_pkg::OP_START:     cmd.start     = 1'b1;
                wsfcs_pkg::OP_TICK:      cmd.rd_issue  = status.sending;
                default:                 cmd           = '0;
            endcase
        end
        // read data is registered, so the byte is emitted from the emit state once the output register is free
        if (state_reg == wsfcs_pkg::ST_EMIT)
        begin
            cmd.emit = status.out_free;
        end
    end

endmodule

### src/wsfcs_dp.sv
// datapath: pixel store, send counters, code registers and output register
module wsfcs_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  wsfcs_pkg::ctrl_cmd_t                  cmd,
    output wsfcs_pkg::ctrl_status_t               status,
    input  logic [wsfcs_pkg::IDX_W-1:0]           pixel_index,
    input  logic [wsfcs_pkg::COLOR_BITS-1:0]      color_grb,
    input  logic                                  cfg_we,
    input  logic [wsfcs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [wsfcs_pkg::CODE_W-1:0]          cfg_data,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [wsfcs_pkg::CODE_W-1:0]          code_byte,
    output logic                                  last_byte
);

    logic [wsfcs_pkg::COLOR_BITS-1:0] pix_mem [wsfcs_pkg::LED_COUNT];
    logic [wsfcs_pkg::LED_COUNT-1:0]  valid_reg;
    logic [wsfcs_pkg::COLOR_BITS-1:0] fill_reg;
    logic [wsfcs_pkg::COLOR_BITS-1:0] rd_data_reg;
    logic                             rd_valid_reg;

    logic [wsfcs_pkg::LED_AW-1:0]     led_reg;
    logic [wsfcs_pkg::BIT_W-1:0]      bit_reg;
    logic                             sending_reg;

    logic [wsfcs_pkg::CODE_W-1:0]     one_code_reg;
    logic [wsfcs_pkg::CODE_W-1:0]     zero_code_reg;

    logic                             out_valid_reg;
    logic [wsfcs_pkg::CODE_W-1:0]     out_code_reg;
    logic                             out_last_reg;

    logic                             idx_ok;
    logic [wsfcs_pkg::LED_AW-1:0]     wr_addr;
    logic                             pix_we;
    logic [wsfcs_pkg::COLOR_BITS-1:0] pix_wdata;
    logic [wsfcs_pkg::COLOR_BITS-1:0] pix;
    logic                             is_last;
    logic [wsfcs_pkg::CODE_W-1:0]     code;

    assign idx_ok    = {1'b0, pixel_index} < (wsfcs_pkg::IDX_W + 1)'(wsfcs_pkg::LED_COUNT);
    assign wr_addr   = pixel_index[wsfcs_pkg::LED_AW-1:0];
    assign pix_we    = (cmd.set_pixel || cmd.clr_pixel) && idx_ok;
    assign pix_wdata = cmd.set_pixel ? color_grb : '0;

    // pixel store, registered read
    always_ff @(posedge clk)
    begin
        if (pix_we)
        begin
            pix_mem[wr_addr] <= pix_wdata;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= pix_mem[led_reg];
        end
    end

    // an entry not written since the last clear-all or fill-all reads as fill_reg
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            fill_reg     <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_all || cmd.fill_all)
            begin
                valid_reg <= '0;
                fill_reg  <= cmd.fill_all ? color_grb : '0;
            end
            else if (pix_we)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.rd_issue)
            begin
                rd_valid_reg <= valid_reg[led_reg];
            end
        end
    end

    assign pix     = rd_valid_reg ? rd_data_reg : fill_reg;
    assign is_last = (led_reg == wsfcs_pkg::LED_LAST) && (bit_reg == '0);
    assign code    = pix[bit_reg] ? one_code_reg : zero_code_reg;

    // frame position: led counter and bit counter, msb first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sending_reg <= 1'b0;
            led_reg     <= '0;
            bit_reg     <= wsfcs_pkg::BIT_MSB;
        end
        else if (cmd.start)
        begin
            sending_reg <= 1'b1;
            led_reg     <= '0;
            bit_reg     <= wsfcs_pkg::BIT_MSB;
        end
        else if (cmd.emit)
        begin
            if (is_last)
            begin
                sending_reg <= 1'b0;
                led_reg     <= '0;
                bit_reg     <= wsfcs_pkg::BIT_MSB;
            end
            else if (bit_reg == '0)
            begin
                led_reg <= led_reg + 1'b1;
                bit_reg <= wsfcs_pkg::BIT_MSB;
            end
            else
            begin
                bit_reg <= bit_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_code_reg  <= wsfcs_pkg::ONE_CODE_RST;
            zero_code_reg <= wsfcs_pkg::ZERO_CODE_RST;
        end
        else if (cfg_we)
        begin
            unique case (wsfcs_pkg::cfg_reg_t'(cfg_index))
                wsfcs_pkg::REG_ONE_CODE:  one_code_reg  <= cfg_data;
                wsfcs_pkg::REG_ZERO_CODE: zero_code_reg <= cfg_data;
                default:                  one_code_reg  <= one_code_reg;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_code_reg <= code;
            out_last_reg <= is_last;
        end
    end

    assign status.sending  = sending_reg;
    assign status.out_free = !out_valid_reg || m_tready;

    assign m_tvalid  = out_valid_reg;
    assign code_byte = out_code_reg;
    assign last_byte = out_last_reg;

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || m_tready))
        else $error("byte emitted while output register still held");

    a_emit_needs_send: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sending_reg)
        else $error("byte emitted with no frame in progress");

    a_send_ends_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(sending_reg) |-> $past(cmd.emit && is_last))
        else $error("send ended without the last byte");

    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_reg <= wsfcs_pkg::BIT_MSB)
        else $error("bit counter out of range");

endmodule

### src/ws2812_frame_code_serializer.sv
// top level of the led strip frame buffer and code byte serializer
//
// input channel s_*: one operation per transaction (set pixel, clear pixel,
// clear all, fill all, start send, tick). set and clear pixel with an index
// at or past the led count are dropped. clear all and fill all act
// on every entry through per-entry valid bits and a fill color register.
// output channel m_*: one code byte per tick while a frame is being sent,
// green, red, blue msb first from led 0 upward; m_tlast marks the last byte.
// a tick while idle is consumed with no output.
// a sending tick holds s_tready low while the pixel store is read into a
// register and its byte is loaded into the output register, from which it
// appears on m_*.
// when the receiver stalls, one byte waits in the output register; ops keep
// flowing until the next sending tick is accepted, whose byte then waits and
// holds s_tready low until the waiting byte is taken.
// reset: store reads as all zero, no frame in progress, one_code 248,
// zero_code 192. cfg_* writes the code registers (index 0 one_code,
// index 1 zero_code); the user writes them only while idle (not enforced).
module ws2812_frame_code_serializer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // op [2:0], pixel index [12:3], color_grb [36:13], zero [39:37]
    input  logic [wsfcs_pkg::S_DATA_W-1:0]        s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // code_byte [7:0]
    output logic [wsfcs_pkg::M_DATA_W-1:0]        m_tdata,
    output logic                                  m_tlast,
    input  logic                                  cfg_we,
    input  logic [wsfcs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [wsfcs_pkg::CODE_W-1:0]          cfg_data
);

    wsfcs_pkg::ctrl_cmd_t    cmd;
    wsfcs_pkg::ctrl_status_t status;

    wsfcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (s_tdata[2:0]),
        .status   (status),
        .cmd      (cmd)
    );

    wsfcs_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .pixel_index (s_tdata[12:3]),
        .color_grb   (s_tdata[36:13]),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .code_byte   (m_tdata),
        .last_byte   (m_tlast)
    );

endmodule

### dv/wsfcs_frame_checker.sv
// frame buffer predictor and code byte checker for the led strip serializer
module wsfcs_frame_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    // op [2:0], pixel index [12:3], color_grb [36:13], zero [39:37]
    input  logic [wsfcs_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    // code_byte [7:0]
    input  logic [wsfcs_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [wsfcs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wsfcs_pkg::CODE_W-1:0]      cfg_data,
    output int                                fail_count,
    output int                                expected_left
);

    localparam int FRAME_BITS = wsfcs_pkg::LED_COUNT * wsfcs_pkg::COLOR_BITS;

    typedef struct packed {
        logic [wsfcs_pkg::CODE_W-1:0] code;
        logic                         last;
    } code_beat_t;

    code_beat_t                       due_codes[$];
    logic [wsfcs_pkg::COLOR_BITS-1:0] led_color [wsfcs_pkg::LED_COUNT];
    int                               frame_bit;
    logic                             frame_active;
    logic [wsfcs_pkg::CODE_W-1:0]     one_code_q;
    logic [wsfcs_pkg::CODE_W-1:0]     zero_code_q;
    int                               mismatches;

    always @(posedge clk or negedge rst_n)
    begin
        code_beat_t                       want;
        logic [wsfcs_pkg::OP_W-1:0]       op;
        logic [wsfcs_pkg::IDX_W-1:0]      idx;
        logic [wsfcs_pkg::COLOR_BITS-1:0] color;
        logic [wsfcs_pkg::COLOR_BITS-1:0] pix;
        int                               led;
        int                               bit_no;
        if (!rst_n)
        begin
            for (int i = 0; i < wsfcs_pkg::LED_COUNT; i++)
                led_color[i] = '0;
            frame_bit    = 0;
            frame_active = 1'b0;
            one_code_q   = wsfcs_pkg::ONE_CODE_RST;
            zero_code_q  = wsfcs_pkg::ZERO_CODE_RST;
            due_codes.delete();
            mismatches   = 0;
        end
        else
        begin
            // results come from earlier ticks, so retire before predicting
            if (m_tvalid && m_tready)
            begin
                if (due_codes.size() == 0)
                begin
                    $error("code byte %0h arrived with no tick waiting", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = due_codes.pop_front();
                    if (m_tdata !== want.code)
                    begin
                        $error("code_byte mismatch: expected %0h, actual %0h",
                               want.code, m_tdata);
                        mismatches++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last_byte mismatch: expected %0b, actual %0b",
                               want.last, m_tlast);
                        mismatches++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    wsfcs_pkg::REG_ONE_CODE:  one_code_q  = cfg_data;
                    wsfcs_pkg::REG_ZERO_CODE: zero_code_q = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                op    = s_tdata[2:0];
                idx   = s_tdata[12:3];
                color = s_tdata[36:13];
                case (op)
                    wsfcs_pkg::OP_SET_PIXEL:
                        if (idx < wsfcs_pkg::LED_COUNT)
                            led_color[idx] = color;
                    wsfcs_pkg::OP_CLR_PIXEL:
                        if (idx < wsfcs_pkg::LED_COUNT)
                            led_color[idx] = '0;
                    wsfcs_pkg::OP_CLR_ALL:
                        for (int i = 0; i < wsfcs_pkg::LED_COUNT; i++)
                            led_color[i] = '0;
                    wsfcs_pkg::OP_FILL_ALL:
                        for (int i = 0; i < wsfcs_pkg::LED_COUNT; i++)
                            led_color[i] = color;
                    wsfcs_pkg::OP_START:
                    begin
                        frame_active = 1'b1;
                        frame_bit    = 0;
                    end
                    wsfcs_pkg::OP_TICK:
                        if (frame_active)
                        begin
                            led       = frame_bit / wsfcs_pkg::COLOR_BITS;
                            bit_no    = frame_bit % wsfcs_pkg::COLOR_BITS;
                            pix       = (led < wsfcs_pkg::LED_COUNT) ? led_color[led] : '0;
                            want.code = pix[wsfcs_pkg::COLOR_BITS-1-bit_no] ?
                                        one_code_q : zero_code_q;
                            want.last = (frame_bit + 1 >= FRAME_BITS);
                            due_codes.push_back(want);
                            if (want.last)
                            begin
                                frame_active = 1'b0;
                                frame_bit    = 0;
                            end
                            else
                                frame_bit = frame_bit + 1;
                        end
                    default: ;
                endcase
            end
        end
        fail_count    <= mismatches;
        expected_left <= due_codes.size();
    end

endmodule

### dv/tb_ws2812_frame_code_serializer.sv
// stimulus and verdict for the led strip frame code serializer
module tb_ws2812_frame_code_serializer;

    localparam int FRAME_BITS  = wsfcs_pkg::LED_COUNT * wsfcs_pkg::COLOR_BITS;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [wsfcs_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [wsfcs_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [wsfcs_pkg::S_DATA_W-1:0]    s_tdata;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [wsfcs_pkg::M_DATA_W-1:0]    m_tdata;
    logic                              m_tlast;
    logic                              cfg_we;
    logic [wsfcs_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [wsfcs_pkg::CODE_W-1:0]      cfg_data;

    int   fail_count;
    int   expected_left;
    int   cycle_count = 0;
    int   stall_left  = 0;
    int   run_left    = 0;
    logic quiet       = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    ws2812_frame_code_serializer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    wsfcs_frame_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .expected_left (expected_left)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver: stall bursts between runs of ready, none once quiet
    always @(negedge clk)
    begin
        if (quiet)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (run_left > 0)
        begin
            run_left--;
            m_tready <= 1'b1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            stall_left = $urandom_range(1, 17) - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            run_left = $urandom_range(1, 40);
            m_tready <= 1'b1;
        end
    end

    function automatic logic [wsfcs_pkg::IDX_W-1:0] pick_index();
        if ($urandom_range(0, 4) == 0)
            return wsfcs_pkg::IDX_W'($urandom_range(0, 1023));
        return wsfcs_pkg::IDX_W'($urandom_range(0, wsfcs_pkg::LED_COUNT - 1));
    endfunction

    function automatic logic [wsfcs_pkg::COLOR_BITS-1:0] rand_color();
        return wsfcs_pkg::COLOR_BITS'($urandom());
    endfunction

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_op(input logic [wsfcs_pkg::OP_W-1:0] op,
                           input logic [wsfcs_pkg::IDX_W-1:0] idx,
                           input logic [wsfcs_pkg::COLOR_BITS-1:0] color);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, color, idx, op};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic wait_drained;
        s_tvalid <= 1'b0;
        while (expected_left != 0)
            @(negedge clk);
        // ops with no byte may still be in flight
        repeat (4) @(negedge clk);
    endtask

    task automatic load_codes(input logic [wsfcs_pkg::CODE_W-1:0] one_val,
                              input logic [wsfcs_pkg::CODE_W-1:0] zero_val);
        cfg_we    <= 1'b1;
        cfg_index <= wsfcs_pkg::REG_ONE_CODE;
        cfg_data  <= one_val;
        @(negedge clk);
        cfg_index <= wsfcs_pkg::REG_ZERO_CODE;
        cfg_data  <= zero_val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_op;
        int r;
        r = $urandom_range(0, 99);
        if (r < 52)
            send_op(wsfcs_pkg::OP_TICK, pick_index(), rand_color());
        else if (r < 55)
            send_op(wsfcs_pkg::OP_START, pick_index(), rand_color());
        else if (r < 72)
            send_op(wsfcs_pkg::OP_SET_PIXEL, pick_index(), rand_color());
        else if (r < 82)
            send_op(wsfcs_pkg::OP_CLR_PIXEL, pick_index(), rand_color());
        else if (r < 86)
            send_op(wsfcs_pkg::OP_CLR_ALL, pick_index(), rand_color());
        else if (r < 92)
            send_op(wsfcs_pkg::OP_FILL_ALL, pick_index(), rand_color());
        else if (r < 96)
            send_op(OP_SPARE_6, pick_index(), rand_color());
        else
            send_op(OP_SPARE_7, pick_index(), rand_color());
    endtask

    initial
    begin
        int r;
        int ticks_sent;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = wsfcs_pkg::REG_ONE_CODE;
        cfg_data  = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed pass at reset codes
        send_op(wsfcs_pkg::OP_FILL_ALL, 10'd0, 24'hC3A501);
        send_op(wsfcs_pkg::OP_SET_PIXEL, 10'd0, 24'hFFFFFF);
        send_op(wsfcs_pkg::OP_SET_PIXEL, 10'd1, 24'h000000);
        send_op(wsfcs_pkg::OP_SET_PIXEL, 10'd64, 24'h123456);
        send_op(wsfcs_pkg::OP_SET_PIXEL, 10'd1023, 24'hFFFFFF);
        send_op(wsfcs_pkg::OP_CLR_PIXEL, 10'd1023, 24'hFFFFFF);
        send_op(wsfcs_pkg::OP_CLR_PIXEL, 10'd63, 24'h000000);
        send_op(wsfcs_pkg::OP_TICK, 10'd0, 24'h000000);
        send_op(OP_SPARE_6, 10'd5, 24'h5A5A5A);
        send_op(OP_SPARE_7, 10'd1023, 24'hFFFFFF);
        send_op(wsfcs_pkg::OP_START, 10'd0, 24'h000000);
        repeat (3) send_op(wsfcs_pkg::OP_TICK, 10'd0, 24'h000000);
        // store write mid-frame shows up in the next bytes
        send_op(wsfcs_pkg::OP_SET_PIXEL, 10'd0, 24'h000000);
        repeat (2) send_op(wsfcs_pkg::OP_TICK, 10'd1023, 24'hFFFFFF);
        send_op(wsfcs_pkg::OP_CLR_ALL, 10'd0, 24'h000000);
        send_op(wsfcs_pkg::OP_TICK, 10'd0, 24'h000000);
        send_op(wsfcs_pkg::OP_START, 10'd0, 24'h000000);
        send_op(wsfcs_pkg::OP_TICK, 10'd0, 24'h000000);
        send_op(wsfcs_pkg::OP_FILL_ALL, 10'd0, 24'hFFFFFF);
        send_op(wsfcs_pkg::OP_TICK, 10'd0, 24'h000000);
        wait_drained();

        load_codes(8'h00, 8'hFF);
        repeat (120)
        begin
            random_op();
            if ($urandom_range(0, 49) == 0)
                wait_drained();
        end
        wait_drained();

        // one whole frame without restart, with store writes sprinkled in
        load_codes(8'hFF, 8'h00);
        send_op(wsfcs_pkg::OP_FILL_ALL, pick_index(), rand_color());
        repeat (12)
            send_op(wsfcs_pkg::OP_SET_PIXEL,
                    wsfcs_pkg::IDX_W'($urandom_range(0, wsfcs_pkg::LED_COUNT - 1)),
                    rand_color());
        send_op(wsfcs_pkg::OP_START, pick_index(), rand_color());
        ticks_sent = 0;
        while (ticks_sent < FRAME_BITS)
        begin
            r = $urandom_range(0, 299);
            if (r < 6)
                send_op(wsfcs_pkg::OP_SET_PIXEL, pick_index(), rand_color());
            else if (r < 10)
                send_op(wsfcs_pkg::OP_CLR_PIXEL, pick_index(), rand_color());
            else if (r == 10)
                send_op(wsfcs_pkg::OP_FILL_ALL, pick_index(), rand_color());
            else if (r == 11)
                send_op(wsfcs_pkg::OP_CLR_ALL, pick_index(), rand_color());
            else
            begin
                send_op(wsfcs_pkg::OP_TICK, pick_index(), rand_color());
                ticks_sent++;
            end
        end
        // frame is over, these ticks find the sender idle
        repeat (3) send_op(wsfcs_pkg::OP_TICK, pick_index(), rand_color());
        wait_drained();

        quiet <= 1'b1;
        load_codes(wsfcs_pkg::CODE_W'($urandom()), wsfcs_pkg::CODE_W'($urandom()));
        repeat (120) random_op();
        wait_drained();

        if (fail_count == 0 && expected_left == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
